FILE: design/frame_threshold_binarizer_assert.svh
// ----------------------------------------------------------------------------
// frame_threshold_binarizer assertion macros
// Shared property shorthands for the modules of the binarizer.
// ----------------------------------------------------------------------------
`ifndef FRAME_THRESHOLD_BINARIZER_ASSERT_SVH
`define FRAME_THRESHOLD_BINARIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ftb_pkg.sv
// ----------------------------------------------------------------------------
// ftb_pkg
// Types, codes and constants shared by the frame threshold binarizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ftb_pkg;

  localparam int unsigned GREY_LEVELS      = 256;
  localparam int unsigned MAX_FRAME_PIXELS = 131072;
  localparam int unsigned COUNT_CAP        = 131071;
  localparam int unsigned COUNT_LIMIT      =
    (MAX_FRAME_PIXELS < COUNT_CAP) ? MAX_FRAME_PIXELS : COUNT_CAP;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned PROD_W  = 42;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned SQ_W    = 84;
  localparam int unsigned WIDE_W  = 128;
  localparam int unsigned MUL_B_W = 42;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned SCAN_W  = 9;

  // mean level: q * 7 / 10 + 10, the divide by ten as a reciprocal multiply
  localparam int unsigned MEAN_T_W    = 11;
  localparam int unsigned MEAN_M_W    = 27;
  localparam int unsigned RECIP_TEN   = 52429;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [PIX_W-1:0] MEAN_OFFSET = 8'd10;

  localparam logic [PIX_W-1:0] FIXED_RESET = 8'd100;

  localparam logic CMD_HIST = 1'b0;
  localparam logic CMD_BIN  = 1'b1;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_BINARY = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_FIXED = 1'b1;

  typedef enum logic [1:0] {
    MODE_MEAN  = 2'd0,
    MODE_OTSU  = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_e;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] level;
    logic             bright;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BIN,
    ST_HWR,
    ST_DECIDE,
    ST_DIV,
    ST_MEAN,
    ST_SCAN,
    ST_RANGE,
    ST_WRD,
    ST_WACC,
    ST_WPQ,
    ST_WD,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_L_GO,
    ST_L_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_NEXT,
    ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_OUT_BIN,
    OP_HIST_RD,
    OP_HIST_WR,
    OP_LEVEL_FIXED,
    OP_LEVEL_KEEP,
    OP_LEVEL_ZERO,
    OP_DIV_GO,
    OP_LEVEL_MEAN,
    OP_SCAN_START,
    OP_SCAN,
    OP_LEVEL_LO,
    OP_WALK_START,
    OP_WALK_RD,
    OP_WALK_ACC,
    OP_WALK_PQ,
    OP_WALK_D,
    OP_MUL_SQ,
    OP_SQ_FIRST,
    OP_SQ_TAKE,
    OP_MUL_L,
    OP_L_TAKE,
    OP_MUL_R,
    OP_CMP,
    OP_WALK_NEXT,
    OP_LEVEL_BEST,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  item_cmd;
    logic  item_last;
    logic  counted;
    mode_e mode;
    logic  total_zero;
    logic  scan_end;
    logic  trivial;
    logic  first;
    logic  j_last;
    logic  mul_done;
    logic  div_done;
    logic  out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/ftb_mul.sv
// ----------------------------------------------------------------------------
// ftb_mul
// Shift-add multiplier, one multiplier bit per cycle, early finish.
// ----------------------------------------------------------------------------
`default_nettype none

module ftb_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic [ftb_pkg::WIDE_W-1:0]         a_i,
  input  logic [ftb_pkg::MUL_B_W-1:0]        b_i,
  output logic                               done_o,
  output logic [ftb_pkg::WIDE_W-1:0]         prod_o
);

  logic [ftb_pkg::WIDE_W-1:0]  a_q, acc_q;
  logic [ftb_pkg::MUL_B_W-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (go_i) begin
      b_q <= b_i;
    end else if (b_q != '0) begin
      b_q <= b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      acc_q <= '0;
    end else if (b_q != '0) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
    end
  end

  assign done_o = (b_q == '0);
  assign prod_o = acc_q;

endmodule

`default_nettype wire

FILE: design/ftb_div.sv
// ----------------------------------------------------------------------------
// ftb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftb_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              go_i,
  input  logic [ftb_pkg::SUM_W-1:0]         dividend_i,
  input  logic [ftb_pkg::CNT_W-1:0]         divisor_i,
  output logic                              done_o,
  output logic [ftb_pkg::SUM_W-1:0]         quot_o
);

  logic [ftb_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [ftb_pkg::CNT_W-1:0]     rem_q, div_q;
  logic [ftb_pkg::SUM_W-1:0]     quo_q;
  logic [ftb_pkg::CNT_W:0]       trial, diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[ftb_pkg::SUM_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (go_i) begin
      cnt_q <= ftb_pkg::DIV_CNT_W'(ftb_pkg::SUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[ftb_pkg::CNT_W-1:0] : trial[ftb_pkg::CNT_W-1:0];
      quo_q <= {quo_q[ftb_pkg::SUM_W-2:0], ge};
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: design/ftb_dpath.sv
// ----------------------------------------------------------------------------
// ftb_dpath
// Histogram memory, frame sums, threshold arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftb_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ftb_pkg::ctrl_cmd_t            cmd_i,
  output ftb_pkg::dp_status_t           sts_o,
  input  ftb_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ftb_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [ftb_pkg::PIX_W-1:0]     cfg_data_i
);

  localparam int unsigned PW = ftb_pkg::PIX_W;
  localparam int unsigned CW = ftb_pkg::CNT_W;
  localparam int unsigned SW = ftb_pkg::SUM_W;

  ftb_pkg::op_e       op;
  ftb_pkg::mode_e     mode_q;
  logic [PW-1:0]      fixed_q, active_q, level_q;
  ftb_pkg::in_item_t  item_q;
  logic [CW-1:0]      total_q;
  logic [SW-1:0]      sum_q;

  // histogram store with per-bin valid bits
  logic [CW-1:0]                  hist_mem [ftb_pkg::GREY_LEVELS];
  logic [ftb_pkg::GREY_LEVELS-1:0] hist_vld_q;
  logic [PW-1:0]                  mem_addr;
  logic                           mem_we;
  logic [CW-1:0]                  rd_data_q, hval;
  logic                           rd_vld_q;

  // scan and walk
  logic [ftb_pkg::SCAN_W-1:0] scan_cnt_q;
  logic                       pipe_v_q, found_q, first_q;
  logic [PW-1:0]              pipe_addr_q, lo_q, hi_q, j_q, best_j_q;
  logic [CW-1:0]              wb_q;
  logic [SW-1:0]              sb_q;
  logic [ftb_pkg::PROD_W-1:0] p_q, q_q, d_q;
  logic [ftb_pkg::DEN_W-1:0]  den_q, best_den_q;
  logic [ftb_pkg::SQ_W-1:0]   sq_q, best_sq_q;
  logic [ftb_pkg::WIDE_W-1:0] lhs_q;

  // shared units
  logic                        mul_go, mul_done, div_go, div_done;
  logic [ftb_pkg::WIDE_W-1:0]  mul_a, prod;
  logic [ftb_pkg::MUL_B_W-1:0] mul_b;
  logic [SW-1:0]               quot;

  logic [ftb_pkg::MEAN_T_W-1:0] mean_t;
  logic [ftb_pkg::MEAN_M_W-1:0] mean_m;

  logic                out_valid_q;
  ftb_pkg::out_item_t  out_item_q;
  logic                out_free;

  assign op = cmd_i.op;

  assign hval = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    case (op)
      ftb_pkg::OP_SCAN:    mem_addr = scan_cnt_q[PW-1:0];
      ftb_pkg::OP_WALK_RD: mem_addr = j_q;
      default:             mem_addr = item_q.pixel;
    endcase
  end

  assign mem_we = (op == ftb_pkg::OP_HIST_WR);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_addr] <= hval + 1'b1;
    end
    rd_data_q <= hist_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= hist_vld_q[mem_addr];
      if (op == ftb_pkg::OP_EMIT) begin
        hist_vld_q <= '0;
      end else if (mem_we) begin
        hist_vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  // configuration, frame sums, active level, output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ftb_pkg::MODE_OTSU;
      fixed_q     <= ftb_pkg::FIXED_RESET;
      total_q     <= '0;
      sum_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ftb_pkg::CFG_MODE:  mode_q  <= ftb_pkg::mode_e'(cfg_data_i[1:0]);
          ftb_pkg::CFG_FIXED: fixed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (op == ftb_pkg::OP_HIST_WR) begin
        total_q <= total_q + 1'b1;
        sum_q   <= sum_q + SW'(item_q.pixel);
      end else if (op == ftb_pkg::OP_EMIT) begin
        total_q  <= '0;
        sum_q    <= '0;
        active_q <= level_q;
      end
      if (op == ftb_pkg::OP_OUT_BIN || op == ftb_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign mean_t = (ftb_pkg::MEAN_T_W'(quot[PW-1:0]) << 3) - ftb_pkg::MEAN_T_W'(quot[PW-1:0]);
  assign mean_m = ftb_pkg::MEAN_M_W'(mean_t) * ftb_pkg::MEAN_M_W'(ftb_pkg::RECIP_TEN);

  always_comb begin
    mul_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (op)
      ftb_pkg::OP_MUL_SQ: begin
        mul_go = 1'b1;
        mul_a  = ftb_pkg::WIDE_W'(d_q);
        mul_b  = d_q;
      end
      ftb_pkg::OP_MUL_L: begin
        mul_go = 1'b1;
        mul_a  = ftb_pkg::WIDE_W'(sq_q);
        mul_b  = ftb_pkg::MUL_B_W'(best_den_q);
      end
      ftb_pkg::OP_MUL_R: begin
        mul_go = 1'b1;
        mul_a  = ftb_pkg::WIDE_W'(best_sq_q);
        mul_b  = ftb_pkg::MUL_B_W'(den_q);
      end
      default: ;
    endcase
  end

  assign div_go = (op == ftb_pkg::OP_DIV_GO);

  always_ff @(posedge clk_i) begin
    case (op)
      ftb_pkg::OP_CAPTURE:     item_q  <= in_item_i;
      ftb_pkg::OP_LEVEL_FIXED: level_q <= fixed_q;
      ftb_pkg::OP_LEVEL_KEEP:  level_q <= active_q;
      ftb_pkg::OP_LEVEL_ZERO:  level_q <= '0;
      ftb_pkg::OP_LEVEL_MEAN:
        level_q <= mean_m[ftb_pkg::RECIP_SHIFT +: PW] + ftb_pkg::MEAN_OFFSET;
      ftb_pkg::OP_LEVEL_LO:    level_q <= lo_q;
      ftb_pkg::OP_LEVEL_BEST:  level_q <= best_j_q;
      ftb_pkg::OP_SCAN_START: begin
        scan_cnt_q <= '0;
        pipe_v_q   <= 1'b0;
        found_q    <= 1'b0;
      end
      ftb_pkg::OP_SCAN: begin
        if (!scan_cnt_q[ftb_pkg::SCAN_W-1]) begin
          pipe_v_q    <= 1'b1;
          pipe_addr_q <= scan_cnt_q[PW-1:0];
          scan_cnt_q  <= scan_cnt_q + 1'b1;
        end else begin
          pipe_v_q <= 1'b0;
        end
        if (pipe_v_q && hval != '0) begin
          if (!found_q) begin
            lo_q    <= pipe_addr_q;
            found_q <= 1'b1;
          end
          hi_q <= pipe_addr_q;
        end
      end
      ftb_pkg::OP_WALK_START: begin
        j_q     <= lo_q;
        wb_q    <= '0;
        sb_q    <= '0;
        first_q <= 1'b1;
      end
      ftb_pkg::OP_WALK_ACC: begin
        wb_q <= wb_q + hval;
        sb_q <= sb_q + SW'(hval) * SW'(j_q);
      end
      ftb_pkg::OP_WALK_PQ: begin
        p_q   <= ftb_pkg::PROD_W'(sb_q) * ftb_pkg::PROD_W'(total_q);
        q_q   <= ftb_pkg::PROD_W'(sum_q) * ftb_pkg::PROD_W'(wb_q);
        den_q <= ftb_pkg::DEN_W'(wb_q) * ftb_pkg::DEN_W'(total_q - wb_q);
      end
      ftb_pkg::OP_WALK_D:  d_q <= (p_q > q_q) ? (p_q - q_q) : (q_q - p_q);
      ftb_pkg::OP_SQ_FIRST: begin
        best_sq_q  <= prod[ftb_pkg::SQ_W-1:0];
        best_den_q <= den_q;
        best_j_q   <= j_q;
        first_q    <= 1'b0;
      end
      ftb_pkg::OP_SQ_TAKE: sq_q  <= prod[ftb_pkg::SQ_W-1:0];
      ftb_pkg::OP_L_TAKE:  lhs_q <= prod;
      ftb_pkg::OP_CMP: begin
        // strict greater keeps the first maximum
        if (lhs_q > prod) begin
          best_sq_q  <= sq_q;
          best_den_q <= den_q;
          best_j_q   <= j_q;
        end
      end
      ftb_pkg::OP_WALK_NEXT: j_q <= j_q + 1'b1;
      default: ;
    endcase
    if (op == ftb_pkg::OP_OUT_BIN) begin
      out_item_q.kind   <= ftb_pkg::KIND_BINARY;
      out_item_q.level  <= '0;
      out_item_q.bright <= (item_q.pixel > active_q);
    end else if (op == ftb_pkg::OP_EMIT) begin
      out_item_q.kind   <= ftb_pkg::KIND_THRESH;
      out_item_q.level  <= level_q;
      out_item_q.bright <= 1'b0;
    end
  end

  ftb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  ftb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    sts_o.item_cmd   = item_q.cmd;
    sts_o.item_last  = item_q.last;
    sts_o.counted    = (total_q < CW'(ftb_pkg::COUNT_LIMIT));
    sts_o.mode       = mode_q;
    sts_o.total_zero = (total_q == '0);
    sts_o.scan_end   = scan_cnt_q[ftb_pkg::SCAN_W-1] && !pipe_v_q;
    sts_o.trivial    = (hi_q == lo_q) || (({1'b0, lo_q} + 1'b1) == {1'b0, hi_q});
    sts_o.first      = first_q;
    sts_o.j_last     = (({1'b0, j_q} + 1'b1) == {1'b0, hi_q});
    sts_o.mul_done   = mul_done;
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: design/ftb_ctrl.sv
// ----------------------------------------------------------------------------
// ftb_ctrl
// Sequencer for histogram, binarize and threshold computation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_threshold_binarizer_assert.svh"

module ftb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ftb_pkg::dp_status_t   sts_i,
  output ftb_pkg::ctrl_cmd_t    cmd_o
);

  ftb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftb_pkg::ST_IDLE:   if (in_valid_i) state_d = ftb_pkg::ST_CHECK;
      ftb_pkg::ST_CHECK: begin
        if (sts_i.item_cmd == ftb_pkg::CMD_BIN) state_d = ftb_pkg::ST_BIN;
        else if (sts_i.counted)                 state_d = ftb_pkg::ST_HWR;
        else if (sts_i.item_last)               state_d = ftb_pkg::ST_DECIDE;
        else                                    state_d = ftb_pkg::ST_IDLE;
      end
      ftb_pkg::ST_BIN:    if (sts_i.out_free) state_d = ftb_pkg::ST_IDLE;
      ftb_pkg::ST_HWR:
        state_d = sts_i.item_last ? ftb_pkg::ST_DECIDE : ftb_pkg::ST_IDLE;
      ftb_pkg::ST_DECIDE: begin
        unique case (sts_i.mode)
          ftb_pkg::MODE_MEAN:
            state_d = sts_i.total_zero ? ftb_pkg::ST_EMIT : ftb_pkg::ST_DIV;
          ftb_pkg::MODE_OTSU:
            state_d = sts_i.total_zero ? ftb_pkg::ST_EMIT : ftb_pkg::ST_SCAN;
          default: state_d = ftb_pkg::ST_EMIT;
        endcase
      end
      ftb_pkg::ST_DIV:    if (sts_i.div_done) state_d = ftb_pkg::ST_MEAN;
      ftb_pkg::ST_MEAN:   state_d = ftb_pkg::ST_EMIT;
      ftb_pkg::ST_SCAN:   if (sts_i.scan_end) state_d = ftb_pkg::ST_RANGE;
      ftb_pkg::ST_RANGE:
        state_d = sts_i.trivial ? ftb_pkg::ST_EMIT : ftb_pkg::ST_WRD;
      ftb_pkg::ST_WRD:    state_d = ftb_pkg::ST_WACC;
      ftb_pkg::ST_WACC:   state_d = ftb_pkg::ST_WPQ;
      ftb_pkg::ST_WPQ:    state_d = ftb_pkg::ST_WD;
      ftb_pkg::ST_WD:     state_d = ftb_pkg::ST_SQ_GO;
      ftb_pkg::ST_SQ_GO:  state_d = ftb_pkg::ST_SQ_WAIT;
      ftb_pkg::ST_SQ_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = sts_i.first ? ftb_pkg::ST_NEXT : ftb_pkg::ST_L_GO;
        end
      end
      ftb_pkg::ST_L_GO:   state_d = ftb_pkg::ST_L_WAIT;
      ftb_pkg::ST_L_WAIT: if (sts_i.mul_done) state_d = ftb_pkg::ST_R_GO;
      ftb_pkg::ST_R_GO:   state_d = ftb_pkg::ST_R_WAIT;
      ftb_pkg::ST_R_WAIT: if (sts_i.mul_done) state_d = ftb_pkg::ST_NEXT;
      ftb_pkg::ST_NEXT:
        state_d = sts_i.j_last ? ftb_pkg::ST_EMIT : ftb_pkg::ST_WRD;
      ftb_pkg::ST_EMIT:   if (sts_i.out_free) state_d = ftb_pkg::ST_IDLE;
      default:            state_d = ftb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = ftb_pkg::OP_NONE;
    in_stall_o = (state_q != ftb_pkg::ST_IDLE);
    unique case (state_q)
      ftb_pkg::ST_IDLE:  if (in_valid_i) cmd_o.op = ftb_pkg::OP_CAPTURE;
      ftb_pkg::ST_CHECK: begin
        if (sts_i.item_cmd == ftb_pkg::CMD_HIST && sts_i.counted) begin
          cmd_o.op = ftb_pkg::OP_HIST_RD;
        end
      end
      ftb_pkg::ST_BIN:   if (sts_i.out_free) cmd_o.op = ftb_pkg::OP_OUT_BIN;
      ftb_pkg::ST_HWR:   cmd_o.op = ftb_pkg::OP_HIST_WR;
      ftb_pkg::ST_DECIDE: begin
        unique case (sts_i.mode)
          ftb_pkg::MODE_MEAN:
            cmd_o.op = sts_i.total_zero ? ftb_pkg::OP_LEVEL_ZERO : ftb_pkg::OP_DIV_GO;
          ftb_pkg::MODE_OTSU:
            cmd_o.op = sts_i.total_zero ? ftb_pkg::OP_LEVEL_ZERO : ftb_pkg::OP_SCAN_START;
          ftb_pkg::MODE_FIXED: cmd_o.op = ftb_pkg::OP_LEVEL_FIXED;
          default:             cmd_o.op = ftb_pkg::OP_LEVEL_KEEP;
        endcase
      end
      ftb_pkg::ST_DIV:   ;
      ftb_pkg::ST_MEAN:  cmd_o.op = ftb_pkg::OP_LEVEL_MEAN;
      ftb_pkg::ST_SCAN:  cmd_o.op = ftb_pkg::OP_SCAN;
      ftb_pkg::ST_RANGE:
        cmd_o.op = sts_i.trivial ? ftb_pkg::OP_LEVEL_LO : ftb_pkg::OP_WALK_START;
      ftb_pkg::ST_WRD:   cmd_o.op = ftb_pkg::OP_WALK_RD;
      ftb_pkg::ST_WACC:  cmd_o.op = ftb_pkg::OP_WALK_ACC;
      ftb_pkg::ST_WPQ:   cmd_o.op = ftb_pkg::OP_WALK_PQ;
      ftb_pkg::ST_WD:    cmd_o.op = ftb_pkg::OP_WALK_D;
      ftb_pkg::ST_SQ_GO: cmd_o.op = ftb_pkg::OP_MUL_SQ;
      ftb_pkg::ST_SQ_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.op = sts_i.first ? ftb_pkg::OP_SQ_FIRST : ftb_pkg::OP_SQ_TAKE;
        end
      end
      ftb_pkg::ST_L_GO:  cmd_o.op = ftb_pkg::OP_MUL_L;
      ftb_pkg::ST_L_WAIT: if (sts_i.mul_done) cmd_o.op = ftb_pkg::OP_L_TAKE;
      ftb_pkg::ST_R_GO:  cmd_o.op = ftb_pkg::OP_MUL_R;
      ftb_pkg::ST_R_WAIT: if (sts_i.mul_done) cmd_o.op = ftb_pkg::OP_CMP;
      ftb_pkg::ST_NEXT:
        cmd_o.op = sts_i.j_last ? ftb_pkg::OP_LEVEL_BEST : ftb_pkg::OP_WALK_NEXT;
      ftb_pkg::ST_EMIT:  if (sts_i.out_free) cmd_o.op = ftb_pkg::OP_EMIT;
      default: ;
    endcase
  end

  `FTB_ASSERT_NXT(a_capture_checks, (state_q == ftb_pkg::ST_IDLE) && in_valid_i, state_q == ftb_pkg::ST_CHECK, "accepted item not checked")
  `FTB_ASSERT_IMP(a_load_needs_slot, (cmd_o.op == ftb_pkg::OP_EMIT) || (cmd_o.op == ftb_pkg::OP_OUT_BIN), sts_i.out_free, "output register overwritten")
  `FTB_ASSERT_IMP(a_walk_entry, state_q == ftb_pkg::ST_WRD, ($past(state_q) == ftb_pkg::ST_RANGE) || ($past(state_q) == ftb_pkg::ST_NEXT), "walk entered from wrong state")
  `FTB_ASSERT_NXT(a_sq_leaves, (state_q == ftb_pkg::ST_SQ_WAIT) && sts_i.mul_done, state_q != ftb_pkg::ST_SQ_WAIT, "square wait stuck")

endmodule

`default_nettype wire

FILE: design/frame_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// frame_threshold_binarizer
// Histogram pass builds a threshold (mean, Otsu, fixed or held); binarize pass
// compares pixels against it.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o  in_item_i  {cmd, pixel, last}
//   out       output     out_valid_o/out_stall_i out_item_o {kind, level, bright}
//   cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// a histogram item passes capture, histogram read and histogram write; a
// binarize item also waits for the output register to be free; a stalled
// result holds the next result only. threshold: fixed and held set directly,
// mean via the bit-serial divider, otsu a bin scan plus, per bin walked,
// products on the one-bit-per-cycle shared multiplier.
// reset and each emit clear histogram valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_threshold_binarizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ftb_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ftb_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [ftb_pkg::PIX_W-1:0]     cfg_data_i
);

  ftb_pkg::ctrl_cmd_t  cmd;
  ftb_pkg::dp_status_t sts;

  ftb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire
